// File: sv/smp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CompW      = (ValueWidth > 32) ? 32 : ValueWidth;
  localparam int unsigned NumLanes   = 4;
  localparam int unsigned NumGroups  = 4;
  localparam int unsigned LimW       = 31;

  localparam logic [LimW-1:0] RotCosReset = 31'h4000_0000;
  localparam logic [60:0]     OneQ60      = 61'h1000_0000_0000_0000;

  typedef enum logic [1:0] {
    GrpPos = 2'd0,
    GrpRot = 2'd1,
    GrpLin = 2'd2,
    GrpAng = 2'd3
  } grp_e;

  typedef enum logic [1:0] {
    CfgPosLimit = 2'd0,
    CfgRotCos   = 2'd1,
    CfgLinLimit = 2'd2,
    CfgAngLimit = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LmDelta,
    LmProd,
    LmSquare
  } lane_mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSum,
    StCmp,
    StEmit
  } state_e;

  typedef logic signed [65:0] prod_t;

  typedef struct packed {
    logic       found;
    logic [1:0] grp;
  } grp_hit_t;

  function automatic logic signed [31:0] sext_comp(logic [31:0] v);
    logic signed [31:0] t;
    t = signed'(v << (32 - CompW));
    return t >>> (32 - CompW);
  endfunction

  // lowest set mask bit at or above start
  function automatic grp_hit_t next_group(logic [NumGroups-1:0] mask, logic [2:0] start);
    grp_hit_t hit;
    hit = '0;
    for (int i = NumGroups - 1; i >= 0; i--) begin
      if (mask[i] && (3'(i) >= start)) begin
        hit.found = 1'b1;
        hit.grp   = 2'(i);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: sv/smp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module smp_lane (
  input  wire logic                    clk_i,
  input  wire logic                    ld_i,
  input  wire smp_pkg::lane_mode_e     mode_i,
  input  wire logic [31:0]             a_i,
  input  wire logic [31:0]             b_i,
  input  wire logic [smp_pkg::LimW-1:0] lim_i,
  output smp_pkg::prod_t               prod_o
);

  logic signed [31:0] ca, cb;
  logic signed [32:0] delta, dmag;
  logic signed [32:0] opa_d, opb_d, opa_q, opb_q;
  smp_pkg::prod_t     prod_q;

  always_comb begin
    ca    = smp_pkg::sext_comp(a_i);
    cb    = smp_pkg::sext_comp(b_i);
    delta = {ca[31], ca} - {cb[31], cb};
    dmag  = delta[32] ? -delta : delta;
    case (mode_i)
      smp_pkg::LmDelta: begin
        opa_d = dmag;
        opb_d = dmag;
      end
      smp_pkg::LmProd: begin
        opa_d = {ca[31], ca};
        opb_d = {cb[31], cb};
      end
      smp_pkg::LmSquare: begin
        opa_d = signed'({2'b00, lim_i});
        opb_d = signed'({2'b00, lim_i});
      end
      default: begin
        opa_d = '0;
        opb_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
    prod_q <= 66'(opa_q) * 66'(opb_q);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: sv/smp_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module smp_merge (
  input  wire logic                     clk_i,
  input  wire logic                     rot_i,
  input  wire smp_pkg::prod_t           prod_i [smp_pkg::NumLanes],
  input  wire logic [smp_pkg::LimW-1:0] cos_lim_i,
  output logic                          changed_o
);

  logic signed [66:0] sum_d, sum_q;
  logic [61:0]        limsq_q;
  logic [66:0]        abs_sum;
  logic [60:0]        dot_clamp;

  always_comb begin
    if (rot_i) begin
      sum_d = 67'(prod_i[0]) + 67'(prod_i[1]) + 67'(prod_i[2]) + 67'(prod_i[3]);
    end else begin
      sum_d = 67'(prod_i[0]) + 67'(prod_i[1]) + 67'(prod_i[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    limsq_q <= prod_i[3][61:0];
  end

  always_comb begin
    abs_sum   = sum_q[66] ? 67'(-sum_q) : 67'(sum_q);
    dot_clamp = (abs_sum > 67'(smp_pkg::OneQ60)) ? smp_pkg::OneQ60 : abs_sum[60:0];
    if (rot_i) begin
      changed_o = dot_clamp < {cos_lim_i, 30'b0};
    end else begin
      changed_o = sum_q > signed'({5'b0, limsq_q});
    end
  end

endmodule

`default_nettype wire

// File: sv/state_change_mask_packer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------------
// input     | in_valid_i / in_ready_o     | body_id, group, cur_*, prev_*, final_group
// output    | out_valid_o / out_ready_i   | out_body, chg_mask, is_header, value,
//           |                             | packet_end
// config    | cfg_we_i (no wait)          | cfg_addr_i, cfg_wdata_i
//
// Each request passes through an operand stage, lane multiply, merge sum and compare.
// The four lanes work on one request at a time; a packet then drains one result
// per cycle from the output register while out_ready_i is high.
// A new request is taken once the last result of a packet sits in the output register.
// Reset clears control, mask, limits (cos: 1.0); held component values have no reset.

module state_change_mask_packer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_addr_i,
  input  wire logic [smp_pkg::LimW-1:0]    cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [31:0]                 body_id_i,
  input  wire logic [1:0]                  group_i,
  input  wire logic signed [31:0]          cur_x_i,
  input  wire logic signed [31:0]          cur_y_i,
  input  wire logic signed [31:0]          cur_z_i,
  input  wire logic signed [31:0]          cur_w_i,
  input  wire logic signed [31:0]          prev_x_i,
  input  wire logic signed [31:0]          prev_y_i,
  input  wire logic signed [31:0]          prev_z_i,
  input  wire logic signed [31:0]          prev_w_i,
  input  wire logic                        final_group_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [31:0]                      out_body_o,
  output logic [3:0]                       chg_mask_o,
  output logic                             is_header_o,
  output logic signed [31:0]               value_o,
  output logic                             packet_end_o
);

  smp_pkg::state_e state_q, state_d;

  logic [smp_pkg::LimW-1:0] pos_lim_q, rot_cos_q, lin_lim_q, ang_lim_q;

  logic [smp_pkg::NumGroups-1:0] mask_q, mask_d, mask_new;
  logic [31:0]                   held_body_q;
  logic [31:0]                   held_q [16];
  logic [1:0]                    group_q;
  logic                          final_q;

  logic       hdr_q, hdr_d;
  logic [1:0] eg_q, eg_d, ej_q, ej_d;

  logic        out_valid_q, out_valid_d, out_ld;
  logic [31:0] out_body_q;
  logic [3:0]  out_mask_q;
  logic        out_hdr_q, out_hdr_d, out_end_q, out_end_d;
  logic [31:0] out_val_q, out_val_d;

  logic                      accept;
  logic [31:0]               cur_a  [smp_pkg::NumLanes];
  logic [31:0]               prev_a [smp_pkg::NumLanes];
  smp_pkg::lane_mode_e       lane_mode [smp_pkg::NumLanes];
  logic [smp_pkg::LimW-1:0]  lim_sel;
  smp_pkg::prod_t            prod [smp_pkg::NumLanes];
  logic                      changed;
  smp_pkg::grp_hit_t         hit;
  logic                      comp_done;
  logic [1:0]                comp_last;

  assign in_ready_o = (state_q == smp_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign cur_a[0]  = cur_x_i;
  assign cur_a[1]  = cur_y_i;
  assign cur_a[2]  = cur_z_i;
  assign cur_a[3]  = cur_w_i;
  assign prev_a[0] = prev_x_i;
  assign prev_a[1] = prev_y_i;
  assign prev_a[2] = prev_z_i;
  assign prev_a[3] = prev_w_i;

  always_comb begin
    case (group_i)
      smp_pkg::GrpPos: lim_sel = pos_lim_q;
      smp_pkg::GrpLin: lim_sel = lin_lim_q;
      smp_pkg::GrpAng: lim_sel = ang_lim_q;
      default:         lim_sel = pos_lim_q;
    endcase
    for (int k = 0; k < smp_pkg::NumLanes; k++) begin
      if (group_i == smp_pkg::GrpRot) begin
        lane_mode[k] = smp_pkg::LmProd;
      end else if (k == smp_pkg::NumLanes - 1) begin
        lane_mode[k] = smp_pkg::LmSquare;
      end else begin
        lane_mode[k] = smp_pkg::LmDelta;
      end
    end
  end

  for (genvar k = 0; k < smp_pkg::NumLanes; k++) begin : g_lane
    smp_lane u_lane (
      .clk_i  (clk_i),
      .ld_i   (accept),
      .mode_i (lane_mode[k]),
      .a_i    (cur_a[k]),
      .b_i    (prev_a[k]),
      .lim_i  (lim_sel),
      .prod_o (prod[k])
    );
  end

  smp_merge u_merge (
    .clk_i     (clk_i),
    .rot_i     (group_q == smp_pkg::GrpRot),
    .prod_i    (prod),
    .cos_lim_i (rot_cos_q),
    .changed_o (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lim_q <= '0;
      rot_cos_q <= smp_pkg::RotCosReset;
      lin_lim_q <= '0;
      ang_lim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        smp_pkg::CfgPosLimit: pos_lim_q <= cfg_wdata_i;
        smp_pkg::CfgRotCos:   rot_cos_q <= cfg_wdata_i;
        smp_pkg::CfgLinLimit: lin_lim_q <= cfg_wdata_i;
        smp_pkg::CfgAngLimit: ang_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < smp_pkg::NumLanes; k++) begin
        held_q[{group_i, 2'(k)}] <= smp_pkg::sext_comp(cur_a[k]);
      end
      group_q <= group_i;
      final_q <= final_group_i;
    end
    if (out_ld) begin
      out_body_q <= held_body_q;
      out_mask_q <= mask_q;
      out_hdr_q  <= out_hdr_d;
      out_val_q  <= out_val_d;
      out_end_q  <= out_end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smp_pkg::StIdle;
      mask_q      <= '0;
      held_body_q <= '0;
      hdr_q       <= 1'b0;
      eg_q        <= '0;
      ej_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      hdr_q       <= hdr_d;
      eg_q        <= eg_d;
      ej_q        <= ej_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        held_body_q <= body_id_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    hdr_d       = hdr_q;
    eg_d        = eg_q;
    ej_d        = ej_q;
    out_ld      = 1'b0;
    out_hdr_d   = 1'b0;
    out_val_d   = '0;
    out_end_d   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    mask_new          = mask_q;
    mask_new[group_q] = changed;

    comp_last = (eg_q == smp_pkg::GrpRot) ? 2'd3 : 2'd2;
    comp_done = (ej_q == comp_last);
    if (hdr_q) begin
      hit = smp_pkg::next_group(mask_q, 3'd0);
    end else begin
      hit = smp_pkg::next_group(mask_q, {1'b0, eg_q} + 3'd1);
    end

    case (state_q)
      smp_pkg::StIdle: begin
        if (accept) begin
          state_d = smp_pkg::StMul;
        end
      end
      smp_pkg::StMul: state_d = smp_pkg::StSum;
      smp_pkg::StSum: state_d = smp_pkg::StCmp;
      smp_pkg::StCmp: begin
        state_d = smp_pkg::StIdle;
        mask_d  = mask_new;
        if (final_q) begin
          if (mask_new != '0) begin
            state_d = smp_pkg::StEmit;
            hdr_d   = 1'b1;
          end else begin
            mask_d = '0;
          end
        end
      end
      smp_pkg::StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_ld      = 1'b1;
          out_valid_d = 1'b1;
          if (hdr_q) begin
            out_hdr_d = 1'b1;
            hdr_d     = 1'b0;
            eg_d      = hit.grp;
            ej_d      = '0;
          end else begin
            out_val_d = held_q[{eg_q, ej_q}];
            if (!comp_done) begin
              ej_d = ej_q + 2'd1;
            end else if (hit.found) begin
              eg_d = hit.grp;
              ej_d = '0;
            end else begin
              out_end_d = 1'b1;
              mask_d    = '0;
              state_d   = smp_pkg::StIdle;
            end
          end
        end
      end
      default: state_d = smp_pkg::StIdle;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_body_o    = out_body_q;
  assign chg_mask_o    = out_mask_q;
  assign is_header_o   = out_hdr_q;
  assign value_o       = out_val_q;
  assign packet_end_o  = out_end_q;

endmodule

`default_nettype wire

// File: sv/smp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module smp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [3:0]         chg_mask_o,
  input wire logic               is_header_o,
  input wire logic signed [31:0] value_o,
  input wire logic               packet_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hdr_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_header_o |-> !packet_end_o)
    else $error("header marked as packet end");

  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chg_mask_o != 4'd0)
    else $error("result with empty change mask");

  a_hdr_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_header_o |-> value_o == 32'sd0)
    else $error("header value not zero");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken before previous one finished");

endmodule

bind state_change_mask_packer smp_checker u_smp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .chg_mask_o    (chg_mask_o),
  .is_header_o   (is_header_o),
  .value_o       (value_o),
  .packet_end_o  (packet_end_o)
);

`default_nettype wire

// File: test/state_change_mask_packer_tb.sv
`timescale 1ns / 1ps

module state_change_mask_packer_tb;

  localparam int unsigned WdogLimit = 3000;
  localparam int unsigned MaxShown  = 10;
  localparam int unsigned Settle    = 24;
  localparam int unsigned PhaseReqs = 100;
  localparam logic [30:0] LimMax    = 31'h7FFF_FFFF;
  localparam logic [31:0] OneQ30    = 32'h4000_0000;
  localparam logic signed [67:0] OneQ60 = 68'sd1 <<< 60;

  typedef struct packed {
    logic [31:0]      body;
    smp_pkg::grp_e    grp;
    logic [3:0][31:0] cur;
    logic [3:0][31:0] prv;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [31:0] body;
    logic [3:0]  mask;
    logic        hdr;
    logic [31:0] value;
    logic        pend;
  } pkt_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_addr_i = '0;
  logic [smp_pkg::LimW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [31:0]       body_id_i = '0;
  logic [1:0]        group_i = '0;
  logic signed [31:0] cur_x_i = '0, cur_y_i = '0, cur_z_i = '0, cur_w_i = '0;
  logic signed [31:0] prev_x_i = '0, prev_y_i = '0, prev_z_i = '0, prev_w_i = '0;
  logic              final_group_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [31:0]       out_body_o;
  logic [3:0]        chg_mask_o;
  logic              is_header_o;
  logic signed [31:0] value_o;
  logic              packet_end_o;

  // predictor state
  logic [30:0] limit_reg [4];
  logic [3:0]  mask_acc;
  logic [31:0] held_body;
  logic [31:0] held_vals [16];

  req_t        group_items_q [$];
  pkt_word_t   packet_words_q [$];
  req_t        on_wire = '0;
  logic        item_taken = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int words_seen = 0;
  int packets_seen = 0;
  int idle_cycles = 0;

  state_change_mask_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .body_id_i     (body_id_i),
    .group_i       (group_i),
    .cur_x_i       (cur_x_i),
    .cur_y_i       (cur_y_i),
    .cur_z_i       (cur_z_i),
    .cur_w_i       (cur_w_i),
    .prev_x_i      (prev_x_i),
    .prev_y_i      (prev_y_i),
    .prev_z_i      (prev_z_i),
    .prev_w_i      (prev_w_i),
    .final_group_i (final_group_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_body_o    (out_body_o),
    .chg_mask_o    (chg_mask_o),
    .is_header_o   (is_header_o),
    .value_o       (value_o),
    .packet_end_o  (packet_end_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic smp_pkg::cfg_idx_e limit_of(smp_pkg::grp_e g);
    case (g)
      smp_pkg::GrpPos: return smp_pkg::CfgPosLimit;
      smp_pkg::GrpLin: return smp_pkg::CfgLinLimit;
      default:         return smp_pkg::CfgAngLimit;
    endcase
  endfunction

  // exact sum of squares fits in 68 bits
  function automatic logic vec_moved(logic [3:0][31:0] c, logic [3:0][31:0] p,
                                     logic [30:0] lim);
    logic signed [67:0] d, sum, l;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      d = signed'(c[k]);
      d = d - signed'(p[k]);
      sum = sum + d * d;
    end
    l = {37'd0, lim};
    return sum > l * l;
  endfunction

  function automatic logic rot_moved(logic [3:0][31:0] c, logic [3:0][31:0] p,
                                     logic [30:0] cosl);
    logic signed [67:0] a, b, dot, lim;
    dot = '0;
    for (int k = 0; k < 4; k++) begin
      a = signed'(c[k]);
      b = signed'(p[k]);
      dot = dot + a * b;
    end
    if (dot < 0) dot = -dot;
    if (dot > OneQ60) dot = OneQ60;
    lim = {37'd0, cosl};
    lim = lim <<< 30;
    return dot < lim;
  endfunction

  function automatic void pack_state_change(req_t r);
    logic      moved;
    pkt_word_t w;
    if (r.grp == smp_pkg::GrpRot) begin
      moved = rot_moved(r.cur, r.prv, limit_reg[smp_pkg::CfgRotCos]);
    end else begin
      moved = vec_moved(r.cur, r.prv, limit_reg[limit_of(r.grp)]);
    end
    held_body = r.body;
    for (int k = 0; k < 4; k++) held_vals[4 * r.grp + k] = r.cur[k];
    mask_acc[r.grp] = moved;
    if (!r.last || mask_acc == 4'd0) return;
    w = '{held_body, mask_acc, 1'b1, 32'd0, 1'b0};
    for (int g = 0; g < smp_pkg::NumGroups; g++) begin
      if (mask_acc[g]) begin
        for (int j = 0; j < ((g == smp_pkg::GrpRot) ? 4 : 3); j++) begin
          packet_words_q = {packet_words_q, w};
          w = '{held_body, mask_acc, 1'b0, held_vals[4 * g + j], 1'b0};
        end
      end
    end
    w.pend = 1'b1;
    packet_words_q = {packet_words_q, w};
    mask_acc = 4'd0;
  endfunction

  function automatic logic [3:0][31:0] comps(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z, logic [31:0] w);
    return {w, z, y, x};
  endfunction

  function automatic void queue_item(logic [31:0] id, smp_pkg::grp_e g,
                                     logic [3:0][31:0] c, logic [3:0][31:0] p,
                                     logic last);
    req_t r;
    r.body = id;
    r.grp  = g;
    r.cur  = c;
    r.prv  = p;
    r.last = last;
    group_items_q = {group_items_q, r};
  endfunction

  function automatic logic [31:0] corner_val();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return OneQ30;
    endcase
  endfunction

  function automatic req_t make_item(logic [31:0] id, smp_pkg::grp_e g, logic last,
                                     logic wild);
    req_t        r;
    logic [31:0] span, d, t, a, cosl;
    int          pick, i;
    r.body = id;
    r.grp  = g;
    r.last = last;
    for (int k = 0; k < 4; k++) begin
      r.cur[k] = $urandom;
      r.prv[k] = $urandom;
    end
    pick = wild ? 2 : $urandom_range(9);
    if (g != smp_pkg::GrpRot) begin
      if (pick == 0) begin
        r.cur = r.prv;
      end else if (pick == 1) begin
        for (int k = 0; k < 4; k++) begin
          r.cur[k] = corner_val();
          r.prv[k] = corner_val();
        end
      end else if (pick >= 3) begin
        // deltas around the limit
        span = 32'(64'(limit_reg[limit_of(g)]) * 3 / 5 + 1);
        for (int k = 0; k < 3; k++) begin
          t = $urandom;
          r.prv[k] = {{2{t[31]}}, t[29:0]};
          d = $urandom_range(span);
          r.cur[k] = $urandom_range(1) ? r.prv[k] + d : r.prv[k] - d;
        end
      end
    end else begin
      if (pick == 1) begin
        for (int k = 0; k < 4; k++) r.prv[k] = corner_val();
        r.cur = r.prv;
        if ($urandom_range(1)) for (int k = 0; k < 4; k++) r.cur[k] = -r.prv[k];
      end else if (pick >= 3) begin
        // unit quaternion against a slightly shrunk copy, dot near the cos limit
        i = $urandom_range(3);
        cosl = {1'b0, limit_reg[smp_pkg::CfgRotCos]};
        r.prv = '0;
        r.prv[i] = $urandom_range(1) ? OneQ30 : -OneQ30;
        a = (cosl <= OneQ30) ? $urandom_range(2 * (OneQ30 - cosl) + 4096)
                             : $urandom_range(1 << 20);
        t = OneQ30 - a;
        for (int k = 0; k < 4; k++) begin
          d = $urandom;
          r.cur[k] = {{15{d[16]}}, d[16:0]};
        end
        r.cur[i] = r.prv[i][31] ? -t : t;
        if ($urandom_range(1)) for (int k = 0; k < 4; k++) r.cur[k] = -r.cur[k];
      end
    end
    return r;
  endfunction

  function automatic int queue_random_body();
    int            order [4];
    int            n, j, tmp;
    logic [31:0]   id;
    smp_pkg::grp_e seq [$];
    id = $urandom;
    if ($urandom_range(99) < 82) begin
      for (int k = 0; k < 4; k++) order[k] = k;
      for (int k = 3; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      n = $urandom_range(4, 1);
      for (int k = 0; k < n; k++) seq = {seq, smp_pkg::grp_e'(order[k])};
      if ($urandom_range(9) == 0) begin
        seq = {seq, smp_pkg::grp_e'(order[$urandom_range(n - 1)])};
      end
      for (int k = 0; k < seq.size(); k++) begin
        group_items_q = {group_items_q,
                         make_item(id, seq[k], k == seq.size() - 1, 1'b0)};
      end
      return seq.size();
    end
    // broken bodies: mixed ids, random groups and final flags
    n = $urandom_range(5, 1);
    for (int k = 0; k < n; k++) begin
      group_items_q = {group_items_q,
                       make_item(($urandom_range(3) == 0) ? $urandom : id,
                                 smp_pkg::grp_e'($urandom_range(3)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)))};
    end
    return n;
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(4))
      0:       return 31'd0;
      1:       return LimMax;
      2:       return 31'd1 << 16;
      3:       return 31'($urandom_range(1 << 20));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_cos();
    case ($urandom_range(4))
      0:       return 31'd0;
      1:       return 31'(OneQ30);
      2:       return 31'($urandom_range(OneQ30, 32'h3F00_0000));
      3:       return 31'($urandom_range(LimMax, OneQ30 + 1));
      default: return 31'($urandom_range(OneQ30));
    endcase
  endfunction

  task automatic write_limit(smp_pkg::cfg_idx_e idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    limit_reg[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (group_items_q.size() != 0 || in_valid_i || packet_words_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (Settle) @(posedge clk_i);
  endtask

  function automatic void note_mismatch(string what, pkt_word_t want, pkt_word_t got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("%s: want body %h mask %b hdr %b value %h end %b", what,
               want.body, want.mask, want.hdr, want.value, want.pend);
      $display("  got body %h mask %b hdr %b value %h end %b",
               got.body, got.mask, got.hdr, got.value, got.pend);
    end
  endfunction

  always @(negedge clk_i) begin : feed
    req_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        if (group_items_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = group_items_q.pop_front();
          in_valid_i    <= 1'b1;
          on_wire       <= nxt;
          body_id_i     <= nxt.body;
          group_i       <= nxt.grp;
          cur_x_i       <= nxt.cur[0];
          cur_y_i       <= nxt.cur[1];
          cur_z_i       <= nxt.cur[2];
          cur_w_i       <= nxt.cur[3];
          prev_x_i      <= nxt.prv[0];
          prev_y_i      <= nxt.prv[1];
          prev_z_i      <= nxt.prv[2];
          prev_w_i      <= nxt.prv[3];
          final_group_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch
    pkt_word_t got, want;
    if (rst_ni) begin
      item_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        got = '{out_body_o, chg_mask_o, is_header_o, value_o, packet_end_o};
        words_seen++;
        if (got.pend) packets_seen++;
        if (packet_words_q.size() == 0) begin
          note_mismatch("unexpected packet word", '0, got);
        end else begin
          want = packet_words_q.pop_front();
          if (got.body !== want.body || got.mask !== want.mask || got.hdr !== want.hdr ||
              got.value !== want.value || got.pend !== want.pend)
            note_mismatch("packet word mismatch", want, got);
        end
      end
      if (in_valid_i && in_ready_o) begin
        pack_state_change(on_wire);
        items_sent++;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run
    int count;
    limit_reg[smp_pkg::CfgPosLimit] = '0;
    limit_reg[smp_pkg::CfgRotCos]   = smp_pkg::RotCosReset;
    limit_reg[smp_pkg::CfgLinLimit] = '0;
    limit_reg[smp_pkg::CfgAngLimit] = '0;
    mask_acc  = '0;
    held_body = '0;
    for (int k = 0; k < 16; k++) held_vals[k] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: zero thresholds, cos limit 1.0
    queue_item(32'h0, smp_pkg::GrpPos, '0, '0, 1'b1);
    queue_item(32'hFFFF_FFFF, smp_pkg::GrpPos, comps(1, 0, 0, 0), '0, 1'b0);
    queue_item(32'hFFFF_FFFF, smp_pkg::GrpRot, comps(OneQ30, 0, 0, 0),
               comps(OneQ30, 0, 0, 0), 1'b0);
    queue_item(32'hFFFF_FFFF, smp_pkg::GrpLin, {4{32'h8000_0000}}, {4{32'h7FFF_FFFF}},
               1'b0);
    queue_item(32'hFFFF_FFFF, smp_pkg::GrpAng, comps(5, 5, 5, 0), comps(5, 5, 5, 0), 1'b0);
    queue_item(32'hFFFF_FFFF, smp_pkg::GrpAng, comps(6, 5, 5, 0), comps(5, 5, 5, 0), 1'b1);
    queue_item(32'hA5A5_5A5A, smp_pkg::GrpAng, comps(1, 0, 0, 0), '0, 1'b0);
    queue_item(32'hA5A5_5A5A, smp_pkg::GrpAng, '0, '0, 1'b1);
    queue_item(32'h1234_5678, smp_pkg::GrpRot, comps(0, OneQ30, 0, 0),
               comps(OneQ30, 0, 0, 0), 1'b1);
    queue_item(32'h5A5A_A5A5, smp_pkg::GrpRot, comps(-OneQ30, 0, 0, 0),
               comps(OneQ30, 0, 0, 0), 1'b0);
    queue_item(32'h5A5A_A5A5, smp_pkg::GrpAng, comps(0, 32'hFFFF_FFFF, 0, 0), '0, 1'b1);
    queue_item(32'h0F0F_F0F0, smp_pkg::GrpRot, {4{32'h8000_0000}}, {4{32'h8000_0000}},
               1'b0);
    queue_item(32'h0F0F_F0F0, smp_pkg::GrpPos, comps(0, 0, 32'h7FFF_FFFF, 0), '0, 1'b1);
    queue_item(32'h8000_0001, smp_pkg::GrpPos, comps(32'h7FFF_FFFF, 32'h8000_0000, 0, 0),
               '0, 1'b0);
    queue_item(32'h8000_0001, smp_pkg::GrpRot, comps(0, 0, OneQ30, 0),
               comps(0, 0, 0, OneQ30), 1'b0);
    queue_item(32'h8000_0001, smp_pkg::GrpLin, comps(32'hFFFF_FFFF, 0, 0, 0), '0, 1'b0);
    queue_item(32'h8000_0001, smp_pkg::GrpAng, comps(0, 0, 32'h8000_0000, 0), '0, 1'b1);
    settle();

    // widest limits, cos limit zero
    write_limit(smp_pkg::CfgPosLimit, LimMax);
    write_limit(smp_pkg::CfgRotCos, 31'd0);
    write_limit(smp_pkg::CfgLinLimit, LimMax);
    write_limit(smp_pkg::CfgAngLimit, LimMax);
    queue_item(32'h7777_0000, smp_pkg::GrpPos, {4{32'h8000_0000}}, {4{32'h7FFF_FFFF}},
               1'b0);
    queue_item(32'h7777_0000, smp_pkg::GrpRot, comps(0, OneQ30, 0, 0),
               comps(OneQ30, 0, 0, 0), 1'b0);
    queue_item(32'h7777_0000, smp_pkg::GrpLin, comps(32'h7FFF_FFFF, 0, 0, 0), '0, 1'b0);
    queue_item(32'h7777_0000, smp_pkg::GrpAng, comps(32'h7FFF_FFFF, 1, 0, 0), '0, 1'b1);
    settle();

    // cos limit above 1.0 flags even an unchanged rotation
    write_limit(smp_pkg::CfgRotCos, LimMax);
    queue_item(32'h0000_7777, smp_pkg::GrpRot, comps(0, 0, 0, OneQ30),
               comps(0, 0, 0, OneQ30), 1'b1);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_limit(smp_pkg::CfgPosLimit, pick_limit());
      write_limit(smp_pkg::CfgRotCos, pick_cos());
      write_limit(smp_pkg::CfgLinLimit, pick_limit());
      write_limit(smp_pkg::CfgAngLimit, pick_limit());
      count = 0;
      while (count < PhaseReqs / 2) count += queue_random_body();
      // sender holds until the block has delivered everything
      drain();
      while (count < PhaseReqs) count += queue_random_body();
      settle();
    end

    $display("Covered %0d group requests over directed cases and 4 idle/stall phases,",
             items_sent);
    $display("checking %0d packet words in %0d packets; %0d mismatches.",
             words_seen, packets_seen, mismatches);
    if (mismatches == 0 && packet_words_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
sv/smp_pkg.sv
sv/smp_lane.sv
sv/smp_merge.sv
sv/state_change_mask_packer.sv
sv/smp_checker.sv
test/state_change_mask_packer_tb.sv
